/* hdl/sit_pkg.sv */
package sit_pkg;

  typedef logic signed [15:0] coord_t;  // input coordinate
  typedef logic signed [16:0] diff_t;   // coordinate difference
  typedef logic signed [33:0] prod_t;   // product of two differences
  typedef logic signed [34:0] sum_t;    // sum of two products
  typedef logic signed [35:0] ext_t;    // dot minus squared length
  typedef logic [1:0]         side_t;   // endpoint classification

  localparam side_t SIDE_ZERO = 2'b00;
  localparam side_t SIDE_POS  = 2'b01;
  localparam side_t SIDE_NEG  = 2'b11;

  // True when the product of two classifications is zero or negative.
  function automatic logic pair_ok(side_t a, side_t b);
    pair_ok = !((a != SIDE_ZERO) && (b != SIDE_ZERO) && (a == b));
  endfunction

endpackage

/* hdl/sit_side.sv */
module sit_side (
  input  logic           clk,
  input  sit_pkg::diff_t seg_dx,
  input  sit_pkg::diff_t seg_dy,
  input  sit_pkg::diff_t pt_rx,
  input  sit_pkg::diff_t pt_ry,
  output sit_pkg::side_t side_cls
);
  import sit_pkg::*;

  prod_t p_rxdy_r, p_rydx_r, p_rxdx_r, p_rydy_r, p_dxdx_r, p_dydy_r;
  sum_t  cross_r, dot_r, len_r;
  side_t cls_nxt, cls_r;
  ext_t  beyond;

  // products
  always_ff @(posedge clk) begin
    p_rxdy_r <= prod_t'(pt_rx) * prod_t'(seg_dy);
    p_rydx_r <= prod_t'(pt_ry) * prod_t'(seg_dx);
    p_rxdx_r <= prod_t'(pt_rx) * prod_t'(seg_dx);
    p_rydy_r <= prod_t'(pt_ry) * prod_t'(seg_dy);
    p_dxdx_r <= prod_t'(seg_dx) * prod_t'(seg_dx);
    p_dydy_r <= prod_t'(seg_dy) * prod_t'(seg_dy);
  end

  // cross, dot and squared length
  always_ff @(posedge clk) begin
    cross_r <= sum_t'(p_rxdy_r) - sum_t'(p_rydx_r);
    dot_r   <= sum_t'(p_rxdx_r) + sum_t'(p_rydy_r);
    len_r   <= sum_t'(p_dxdx_r) + sum_t'(p_dydy_r);
  end

  // projection past the far end: dot - |d|^2
  assign beyond = ext_t'(dot_r) - ext_t'(len_r);

  always_comb begin
    if (cross_r != '0) begin
      cls_nxt = cross_r[34] ? SIDE_NEG : SIDE_POS;
    end else if (dot_r[34]) begin
      cls_nxt = SIDE_NEG;
    end else if (dot_r == '0) begin
      cls_nxt = SIDE_ZERO;
    end else begin
      cls_nxt = (!beyond[35] && (beyond != '0)) ? SIDE_POS : SIDE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  assign side_cls = cls_r;

endmodule

/* hdl/segment_intersection_test.sv */
// An item accepted at a clock edge shows its result strobe (out_valid) once it
// has passed the registers for differences, products, sums, classification, output reg.
// Throughput: one item per cycle; the six 17x17 multipliers of each side unit
// are fully pipelined. busy is held low, as the receiver cannot stall.
// Reset: synchronous, active low; clears the valid pipeline only.
module segment_intersection_test (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sit_pkg::coord_t in_first_start_x,
  input  sit_pkg::coord_t in_first_start_y,
  input  sit_pkg::coord_t in_first_end_x,
  input  sit_pkg::coord_t in_first_end_y,
  input  sit_pkg::coord_t in_second_start_x,
  input  sit_pkg::coord_t in_second_start_y,
  input  sit_pkg::coord_t in_second_end_x,
  input  sit_pkg::coord_t in_second_end_y,
  output logic            out_valid,
  output logic            out_segments_meet
);
  import sit_pkg::*;

  logic       accept;
  logic [3:0] vld_r, vld_nxt;
  logic       out_valid_r, out_meet_r;

  diff_t d1x_r, d1y_r, d2x_r, d2y_r;
  diff_t rcx_r, rcy_r, rdx_r, rdy_r, rax_r, ray_r, rbx_r, rby_r;
  side_t cls_c, cls_d, cls_a, cls_b;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    d1x_r <= diff_t'(in_first_end_x)   - diff_t'(in_first_start_x);
    d1y_r <= diff_t'(in_first_end_y)   - diff_t'(in_first_start_y);
    d2x_r <= diff_t'(in_second_end_x)  - diff_t'(in_second_start_x);
    d2y_r <= diff_t'(in_second_end_y)  - diff_t'(in_second_start_y);
    rcx_r <= diff_t'(in_second_start_x) - diff_t'(in_first_start_x);
    rcy_r <= diff_t'(in_second_start_y) - diff_t'(in_first_start_y);
    rdx_r <= diff_t'(in_second_end_x)  - diff_t'(in_first_start_x);
    rdy_r <= diff_t'(in_second_end_y)  - diff_t'(in_first_start_y);
    rax_r <= diff_t'(in_first_start_x) - diff_t'(in_second_start_x);
    ray_r <= diff_t'(in_first_start_y) - diff_t'(in_second_start_y);
    rbx_r <= diff_t'(in_first_end_x)   - diff_t'(in_second_start_x);
    rby_r <= diff_t'(in_first_end_y)   - diff_t'(in_second_start_y);
  end

  // second segment's endpoints against the first segment
  sit_side u_side_c (.clk(clk), .seg_dx(d1x_r), .seg_dy(d1y_r),
                     .pt_rx(rcx_r), .pt_ry(rcy_r), .side_cls(cls_c));
  sit_side u_side_d (.clk(clk), .seg_dx(d1x_r), .seg_dy(d1y_r),
                     .pt_rx(rdx_r), .pt_ry(rdy_r), .side_cls(cls_d));
  // first segment's endpoints against the second segment
  sit_side u_side_a (.clk(clk), .seg_dx(d2x_r), .seg_dy(d2y_r),
                     .pt_rx(rax_r), .pt_ry(ray_r), .side_cls(cls_a));
  sit_side u_side_b (.clk(clk), .seg_dx(d2x_r), .seg_dy(d2y_r),
                     .pt_rx(rbx_r), .pt_ry(rby_r), .side_cls(cls_b));

  always_ff @(posedge clk) begin
    out_meet_r <= pair_ok(cls_c, cls_d) && pair_ok(cls_a, cls_b);
  end

  assign out_valid         = out_valid_r;
  assign out_segments_meet = out_meet_r;

endmodule

/* hdl/sit_checker.sv */
module sit_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input sit_pkg::coord_t in_first_start_x,
  input sit_pkg::coord_t in_first_start_y,
  input sit_pkg::coord_t in_second_start_x,
  input sit_pkg::coord_t in_second_start_y,
  input logic            out_valid,
  input logic            out_segments_meet
);
  import sit_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_item_yields: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted item gave no result");

  a_shared_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_first_start_x == in_second_start_x)
     && (in_first_start_y == in_second_start_y)) |-> ##5 out_segments_meet)
    else $error("segments sharing a start point reported apart");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_first_start_x  (in_first_start_x),
  .in_first_start_y  (in_first_start_y),
  .in_second_start_x (in_second_start_x),
  .in_second_start_y (in_second_start_y),
  .out_valid         (out_valid),
  .out_segments_meet (out_segments_meet)
);
